FILE: hw/rtl/adc_seq_pkg.sv
// Shared types and constants of the ADC scan sequencer.
`default_nettype none

package adc_seq_pkg;

  // Item function codes.
  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_WRITE  = 1'b1;

  // Configuration port address width and register indexes (paddr[3:2]).
  localparam int CFG_AW = 4;
  localparam logic [1:0] REG_TEMP_DIVIDER = 2'd0;
  localparam logic [1:0] REG_CONFIG_CHECK = 2'd1;
  localparam logic [1:0] REG_COMPARE_MASK = 2'd2;

  // Iterations of the bit-serial remainder unit.
  localparam int REM_STEPS = 16;

  // One input transaction.
  typedef struct packed {
    logic        func;
    logic [3:0]  chan_sel;
    logic [15:0] cfg_word;
    logic [31:0] rx_data;
  } item_t;

  // One result transaction.
  typedef struct packed {
    logic [15:0]        tx_word;
    logic [3:0]         next_chan;
    logic               report_valid;
    logic [3:0]         report_chan;
    logic signed [15:0] raw_value;
    logic               is_temperature;
    logic               readback_fault;
  } result_t;

  // Register values seen by the datapath.
  typedef struct packed {
    logic [15:0] temp_divider;
    logic        config_check;
    logic [15:0] compare_mask;
  } cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic div_step;
    logic commit;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_write;
    logic div_last;
  } dp_status_t;

endpackage

`default_nettype wire

FILE: hw/rtl/adc_seq_stream_if.sv
// Valid/ready stream interface that carries one payload per transaction.
`default_nettype none

interface adc_seq_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/adc_seq_regs.sv
// APB-style configuration registers of the ADC scan sequencer.
`default_nettype none

module adc_seq_regs (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [adc_seq_pkg::CFG_AW-1:0] paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  output adc_seq_pkg::cfg_t                  cfg
);

  logic [15:0] temp_divider_r;
  logic        config_check_r;
  logic [15:0] compare_mask_r;
  logic        wr_en;
  logic [1:0]  reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  // Register writes on the access cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_divider_r <= 16'd1;
      config_check_r <= 1'b0;
      compare_mask_r <= 16'hFFFF;
    end else if (wr_en) begin
      case (reg_idx)
        adc_seq_pkg::REG_TEMP_DIVIDER: temp_divider_r <= pwdata[15:0];
        adc_seq_pkg::REG_CONFIG_CHECK: config_check_r <= pwdata[0];
        adc_seq_pkg::REG_COMPARE_MASK: compare_mask_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read mux.
  always_comb begin
    case (reg_idx)
      adc_seq_pkg::REG_TEMP_DIVIDER: prdata = {16'd0, temp_divider_r};
      adc_seq_pkg::REG_CONFIG_CHECK: prdata = {31'd0, config_check_r};
      adc_seq_pkg::REG_COMPARE_MASK: prdata = {16'd0, compare_mask_r};
      default:                       prdata = 32'd0;
    endcase
  end

  assign cfg.temp_divider = temp_divider_r;
  assign cfg.config_check = config_check_r;
  assign cfg.compare_mask = compare_mask_r;

endmodule

`default_nettype wire

FILE: hw/rtl/adc_seq_ctrl.sv
// Controller state machine of the ADC scan sequencer.
`default_nettype none

module adc_seq_ctrl (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  input  wire adc_seq_pkg::dp_status_t status,
  output adc_seq_pkg::ctrl_cmd_t       cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_STEP,
    S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r;
  logic   out_valid_r;

  // Next state and commands.
  always_comb begin
    state_nxt    = state_r;
    cmd.load     = 1'b0;
    cmd.div_step = 1'b0;
    cmd.commit   = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready_r) begin
          cmd.load  = 1'b1;
          state_nxt = status.in_write ? S_OUT : S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_nxt = S_STEP;
        end
      end
      S_STEP: begin
        cmd.commit = 1'b1;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State and registered handshake outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_ready_r  <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_ready_r  <= (state_nxt == S_IDLE);
      out_valid_r <= (state_nxt == S_OUT);
    end
  end

  assign in_ready  = in_ready_r;
  assign out_valid = out_valid_r;

  // The two sides never handshake in the same cycle.
  a_ready_valid_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready_r && out_valid_r))
    else $error("input ready while a result is pending");

  // A finished remainder pass leads to the selection step.
  a_div_to_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && status.div_last) |=> (state_r == S_STEP))
    else $error("remainder pass did not lead to the selection step");

  // Once the result is taken, the block is ready for the next transaction.
  a_out_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_ready) |=> (in_ready_r && !out_valid_r))
    else $error("block not ready after result transaction");

  // A write transaction goes straight to the output.
  a_write_direct: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load && status.in_write) |=> out_valid_r)
    else $error("write transaction did not produce a result at once");

endmodule

`default_nettype wire

FILE: hw/rtl/adc_seq_dp.sv
// Datapath of the ADC scan sequencer: channel table, remainder unit, selection.
`default_nettype none

module adc_seq_dp #(
  parameter int NUM_CHANNELS = 9
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire adc_seq_pkg::item_t      in_item,
  input  wire adc_seq_pkg::cfg_t       cfg,
  input  wire adc_seq_pkg::ctrl_cmd_t  cmd,
  output adc_seq_pkg::dp_status_t      status,
  output adc_seq_pkg::result_t         result
);

  localparam int CW = $clog2(NUM_CHANNELS);
  localparam int IW = CW + 1;
  localparam logic [CW-1:0] TEMP_CH = CW'(NUM_CHANNELS - 1);

  logic [15:0]            words_r [NUM_CHANNELS];
  logic [15:0]            temp_phase_r;
  logic [CW-1:0]          last_chan_r;
  logic                   last_none_r;
  logic                   last_valid_r;
  logic [31:0]            rx_r;
  adc_seq_pkg::result_t   res_r, res_nxt;

  // Remainder unit state.
  logic [15:0]            phase_sh_r;
  logic [15:0]            rem_r;
  logic [3:0]             cnt_r;
  logic [15:0]            div_eff;
  logic [16:0]            trial;
  logic                   rem_zero;

  // Selection signals.
  logic [NUM_CHANNELS-1:0] elig;
  logic [CW-1:0]          start;
  logic [IW-1:0]          cand;
  logic [CW-1:0]          pick;
  logic                   found;
  logic [15:0]            tx;
  logic                   fault;
  logic                   rep;

  // Write decode.
  logic                   wr_in_range;
  logic                   wr_en;
  logic                   wr_dec;
  logic [CW-1:0]          wr_idx;

  assign wr_in_range = ({1'b0, in_item.chan_sel} < 5'(NUM_CHANNELS));
  assign wr_idx      = in_item.chan_sel[CW-1:0];
  assign wr_en       = cmd.load && (in_item.func == adc_seq_pkg::FUNC_WRITE) && wr_in_range;
  assign wr_dec      = wr_en && (wr_idx != TEMP_CH) && (in_item.cfg_word != 16'd0);

  assign status.in_write = (in_item.func == adc_seq_pkg::FUNC_WRITE);
  assign status.div_last = (cnt_r == 4'(adc_seq_pkg::REM_STEPS - 1));

  // Divider zero acts as one; restoring remainder step, one bit per cycle.
  assign div_eff  = (cfg.temp_divider == 16'd0) ? 16'd1 : cfg.temp_divider;
  assign trial    = {rem_r, phase_sh_r[15]};
  assign rem_zero = (rem_r == 16'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.load) begin
      cnt_r <= '0;
    end else if (cmd.div_step) begin
      cnt_r <= cnt_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      phase_sh_r <= temp_phase_r;
      rem_r      <= '0;
      rx_r       <= in_item.rx_data;
    end else if (cmd.div_step) begin
      phase_sh_r <= {phase_sh_r[14:0], 1'b0};
      if (trial >= {1'b0, div_eff}) begin
        rem_r <= 16'(trial - {1'b0, div_eff});
      end else begin
        rem_r <= trial[15:0];
      end
    end
  end

  // Eligibility of each channel; the temperature channel needs a zero remainder.
  always_comb begin
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      elig[i] = (words_r[i] != 16'd0) && ((i != NUM_CHANNELS - 1) || rem_zero);
    end
  end

  // Round-robin pick starting after the last started channel.
  assign start = (last_none_r || last_chan_r == TEMP_CH) ? '0 : (last_chan_r + CW'(1));

  always_comb begin
    found = 1'b0;
    pick  = '0;
    cand  = '0;
    for (int k = 0; k < NUM_CHANNELS; k++) begin
      cand = {1'b0, start} + IW'(k);
      if (cand >= IW'(NUM_CHANNELS)) begin
        cand = cand - IW'(NUM_CHANNELS);
      end
      if (!found && elig[cand[CW-1:0]]) begin
        found = 1'b1;
        pick  = cand[CW-1:0];
      end
    end
  end

  // Result of a sample step.
  assign tx    = found ? words_r[pick] : 16'd0;
  assign fault = cfg.config_check && (tx != 16'd0) &&
                 (((tx ^ rx_r[31:16]) & cfg.compare_mask) != 16'd0);
  assign rep   = last_valid_r;

  always_comb begin
    res_nxt = '0;
    if (cmd.commit) begin
      res_nxt.tx_word        = tx;
      res_nxt.next_chan      = found ? 4'(pick) : 4'(NUM_CHANNELS);
      res_nxt.report_valid   = rep;
      res_nxt.report_chan    = rep ? 4'(last_chan_r) : 4'd0;
      res_nxt.raw_value      = rep ? signed'({rx_r[7:0], rx_r[15:8]}) : 16'sd0;
      res_nxt.is_temperature = rep && (last_chan_r == TEMP_CH);
      res_nxt.readback_fault = fault;
    end else begin
      res_nxt.next_chan      = 4'(NUM_CHANNELS);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit || cmd.load) begin
      res_r <= res_nxt;
    end
  end

  // Channel table and sequencing state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        words_r[i] <= '0;
      end
      temp_phase_r <= '0;
      last_chan_r  <= '0;
      last_none_r  <= 1'b1;
      last_valid_r <= 1'b0;
    end else begin
      if (wr_en) begin
        words_r[wr_idx] <= in_item.cfg_word;
      end
      if (wr_dec) begin
        temp_phase_r <= temp_phase_r - 16'd1;
      end else if (cmd.commit) begin
        temp_phase_r <= temp_phase_r + 16'd1;
      end
      if (cmd.commit) begin
        last_chan_r  <= pick;
        last_none_r  <= !found;
        last_valid_r <= found && !fault;
      end
    end
  end

  assign result = res_r;

  // A reportable channel always refers to a started channel.
  a_valid_not_none: assert property (@(posedge clk) disable iff (!rst_n)
    last_valid_r |-> !last_none_r)
    else $error("report pending without a started channel");

  // The last started channel stays within the table.
  a_last_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    !last_none_r |-> ({1'b0, last_chan_r} < IW'(NUM_CHANNELS)))
    else $error("last channel out of range");

  // A read-back fault blocks the report of the channel just started.
  a_fault_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && fault) |=> !last_valid_r)
    else $error("faulted channel left reportable");

endmodule

`default_nettype wire

FILE: hw/rtl/adc_scan_sequencer_pipelined_readback.sv
// Top level of the round-robin ADC scan sequencer with pipelined readback.
//
//   Port group  Direction  Carries
//   in_ch       sink       item_t: func, chan_sel, cfg_word, rx_data
//   out_ch      source     result_t: tx_word, next_chan, report fields, readback_fault
//   cfg_*       APB slave  temp_divider (0x0), config_check (0x4), compare_mask (0x8)
//
// A sample transaction passes through the bit-serial remainder unit, which tests the
// temperature phase against the divider, and then the selection step before its result
// is offered; a write transaction goes straight to the output.
// One transaction is in flight at a time; in_ch.ready is low until its result is taken.
// Reset (rst_n low, synchronous) clears the table and phase and resets the registers.
`default_nettype none

module adc_scan_sequencer_pipelined_readback #(
  parameter int NUM_CHANNELS = 9
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  adc_seq_stream_if.sink                      in_ch,
  adc_seq_stream_if.source                    out_ch,
  input  wire logic                           cfg_psel,
  input  wire logic                           cfg_penable,
  input  wire logic                           cfg_pwrite,
  input  wire logic [adc_seq_pkg::CFG_AW-1:0] cfg_paddr,
  input  wire logic [31:0]                    cfg_pwdata,
  output logic [31:0]                         cfg_prdata,
  output logic                                cfg_pready
);

  adc_seq_pkg::cfg_t       cfg;
  adc_seq_pkg::ctrl_cmd_t  cmd;
  adc_seq_pkg::dp_status_t status;
  adc_seq_pkg::item_t      in_item;
  adc_seq_pkg::result_t    result;
  logic                    in_ready;
  logic                    out_valid;

  assign in_item = in_ch.payload;

  // Configuration registers.
  adc_seq_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // Sequencing controller.
  adc_seq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Channel table and step datapath.
  adc_seq_dp #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_item (in_item),
    .cfg     (cfg),
    .cmd     (cmd),
    .status  (status),
    .result  (result)
  );

  assign in_ch.ready    = in_ready;
  assign out_ch.valid   = out_valid;
  assign out_ch.payload = result;

endmodule

`default_nettype wire

FILE: dv/adc_scan_sequencer_pipelined_readback_tb.sv
// Self-checking testbench of the ADC scan sequencer: directed table, then random phases.
`timescale 1ns / 1ps

module adc_scan_sequencer_pipelined_readback_tb;

  localparam int NUM_CH = 9;
  localparam logic [3:0] CH_TEMP = 4'(NUM_CH - 1);
  localparam logic [3:0] CH_NONE = 4'(NUM_CH);
  localparam int CYCLE_LIMIT = 400000;
  localparam int RAND_PHASES = 7;
  localparam int ITEMS_PER_PHASE = 90;

  typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_t;

  // One line of the directed table: a transaction or a register write.
  typedef struct {
    row_kind_t            kind;
    logic [1:0]           reg_idx;
    logic [31:0]          reg_val;
    adc_seq_pkg::item_t   item;
    bit                   known;
    adc_seq_pkg::result_t typed;
  } dir_row_t;

  logic clk;
  logic rst_n;
  logic cfg_psel;
  logic cfg_penable;
  logic cfg_pwrite;
  logic [adc_seq_pkg::CFG_AW-1:0] cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  adc_seq_stream_if #(.payload_t(adc_seq_pkg::item_t))   in_ch ();
  adc_seq_stream_if #(.payload_t(adc_seq_pkg::result_t)) out_ch ();

  adc_scan_sequencer_pipelined_readback #(.NUM_CHANNELS(NUM_CH)) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // Shadow of the sequencer: channel table, scan position, phase and registers.
  logic [15:0] chan_word [NUM_CH];
  logic [3:0]  last_started;
  bit          last_reportable;
  logic [15:0] temp_phase;
  logic [15:0] divider_reg;
  bit          check_reg;
  logic [15:0] mask_reg;

  adc_seq_pkg::result_t pending_results[$];
  adc_seq_pkg::result_t expected_now;
  int      mismatches;
  int      cycle_count;
  int      ready_hold;
  bit      quiet;

  // Computes the result of one transaction; the shadow state moves only when commit is set.
  function automatic adc_seq_pkg::result_t predict_scan(adc_seq_pkg::item_t it, bit commit);
    adc_seq_pkg::result_t r;
    int ch;
    int nxt;
    int prev;
    logic [15:0] div;
    logic [15:0] tx;
    logic [15:0] readback;
    bit fault;
    r = '0;
    if (it.func == adc_seq_pkg::FUNC_WRITE) begin
      r.next_chan = CH_NONE;
      if (commit && it.chan_sel < NUM_CH) begin
        chan_word[it.chan_sel] = it.cfg_word;
        if (it.chan_sel != CH_TEMP && it.cfg_word != 16'd0) temp_phase = temp_phase - 16'd1;
      end
      return r;
    end
    div = (divider_reg == 16'd0) ? 16'd1 : divider_reg;
    // Round-robin search from the channel after the last one started.
    nxt = NUM_CH;
    ch = int'(last_started) + 1;
    for (int n = 0; n < NUM_CH; n++) begin
      if (ch >= NUM_CH) ch = 0;
      if (chan_word[ch] != 16'd0 && !(ch == CH_TEMP && (temp_phase % div) != 16'd0)) begin
        nxt = ch;
        break;
      end
      ch++;
    end
    tx = (nxt < NUM_CH) ? chan_word[nxt] : 16'd0;
    prev = last_reportable ? int'(last_started) : NUM_CH;
    readback = it.rx_data[31:16];
    fault = check_reg && tx != 16'd0 && ((tx & mask_reg) != (readback & mask_reg));
    r.tx_word = tx;
    r.next_chan = 4'(nxt);
    if (prev < NUM_CH) begin
      r.report_valid = 1'b1;
      r.report_chan = 4'(prev);
      r.raw_value = {it.rx_data[7:0], it.rx_data[15:8]};
      r.is_temperature = (prev == CH_TEMP);
    end
    r.readback_fault = fault;
    if (commit) begin
      last_started = 4'(nxt);
      last_reportable = (nxt < NUM_CH) && !fault;
      temp_phase = temp_phase + 16'd1;
    end
    return r;
  endfunction

  // Idle length for either side: mostly none or short, now and then long.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic adc_seq_pkg::item_t make_item(logic f, logic [3:0] sel, logic [15:0] w,
                                                   logic [31:0] rx);
    adc_seq_pkg::item_t it;
    it.func = f;
    it.chan_sel = sel;
    it.cfg_word = w;
    it.rx_data = rx;
    return it;
  endfunction

  function automatic dir_row_t item_row(logic f, logic [3:0] sel, logic [15:0] w,
                                        logic [31:0] rx, bit known, logic [15:0] tx,
                                        logic [3:0] nxt);
    dir_row_t row;
    row.kind = ROW_ITEM;
    row.reg_idx = '0;
    row.reg_val = '0;
    row.item = make_item(f, sel, w, rx);
    row.known = known;
    row.typed = '0;
    row.typed.tx_word = tx;
    row.typed.next_chan = nxt;
    return row;
  endfunction

  function automatic dir_row_t cfg_row(logic [1:0] idx, logic [31:0] val);
    dir_row_t row;
    row = item_row(adc_seq_pkg::FUNC_SAMPLE, '0, '0, '0, 1'b0, '0, '0);
    row.kind = ROW_CFG;
    row.reg_idx = idx;
    row.reg_val = val;
    return row;
  endfunction

  // Sends one transaction and queues its expected result once it is accepted.
  task automatic send_item(adc_seq_pkg::item_t it, bit known, adc_seq_pkg::result_t typed);
    adc_seq_pkg::result_t predicted;
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.payload <= it;
    do @(posedge clk); while (!in_ch.ready);
    predicted = predict_scan(it, 1'b1);
    pending_results.push_back(known ? typed : predicted);
  endtask

  task automatic idle_sender(int n);
    repeat (n) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
  endtask

  // Holds the sender off until every queued result has come back.
  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // APB write: setup cycle, then access cycle until pready.
  task automatic cfg_write(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= adc_seq_pkg::CFG_AW'({idx, 2'b00});
    cfg_pwdata <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (idx)
      adc_seq_pkg::REG_TEMP_DIVIDER: divider_reg = val[15:0];
      adc_seq_pkg::REG_CONFIG_CHECK: check_reg = val[0];
      adc_seq_pkg::REG_COMPARE_MASK: mask_reg = val[15:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task automatic cmp_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side: random back-pressure, changed at the falling edge.
  always @(negedge clk) begin
    if (ready_hold > 0) begin
      ready_hold--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      ready_hold = gap_len();
    end
  end

  // Compare every result transaction with the oldest expectation.
  always @(posedge clk) begin
    if (out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result transaction: expected none, actual %h",
                 $time, out_ch.payload);
        mismatches++;
      end else begin
        expected_now = pending_results.pop_front();
        cmp_field("tx_word", expected_now.tx_word, out_ch.payload.tx_word);
        cmp_field("next_chan", expected_now.next_chan, out_ch.payload.next_chan);
        cmp_field("report_valid", expected_now.report_valid, out_ch.payload.report_valid);
        cmp_field("report_chan", expected_now.report_chan, out_ch.payload.report_chan);
        cmp_field("raw_value", expected_now.raw_value, out_ch.payload.raw_value);
        cmp_field("is_temperature", expected_now.is_temperature,
                  out_ch.payload.is_temperature);
        cmp_field("readback_fault", expected_now.readback_fault,
                  out_ch.payload.readback_fault);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    dir_row_t directed_rows[$];
    adc_seq_pkg::item_t it;
    adc_seq_pkg::result_t peek;
    logic [15:0] rb;
    int r;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.payload = '0;
    out_ch.ready = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    mismatches = 0;
    cycle_count = 0;
    ready_hold = 0;
    quiet = 1'b0;
    foreach (chan_word[i]) chan_word[i] = 16'd0;
    last_started = CH_NONE;
    last_reportable = 1'b0;
    temp_phase = 16'd0;
    divider_reg = 16'd1;
    check_reg = 1'b0;
    mask_reg = 16'hFFFF;

    // Empty table after reset, ignored out-of-range writes, then a single channel.
    directed_rows.push_back(item_row(adc_seq_pkg::FUNC_SAMPLE, 4'd0, 16'd0, 32'hFFFF_FFFF,
                                     1'b1, 16'd0, CH_NONE));
    directed_rows.push_back(item_row(adc_seq_pkg::FUNC_WRITE, 4'd15, 16'hFFFF, 32'd0,
                                     1'b1, 16'd0, CH_NONE));
    directed_rows.push_back(item_row(adc_seq_pkg::FUNC_WRITE, 4'd9, 16'h1234, 32'd0,
                                     1'b1, 16'd0, CH_NONE));
    directed_rows.push_back(item_row(adc_seq_pkg::FUNC_SAMPLE, 4'd0, 16'd0, 32'd0,
                                     1'b1, 16'd0, CH_NONE));
    directed_rows.push_back(item_row(adc_seq_pkg::FUNC_WRITE, 4'd0, 16'hFFFF, 32'd0,
                                     1'b1, 16'd0, CH_NONE));
    directed_rows.push_back(item_row(adc_seq_pkg::FUNC_SAMPLE, 4'd0, 16'd0, 32'h0000_0080,
                                     1'b1, 16'hFFFF, 4'd0));
    // Largest and smallest conversion after byte swapping.
    directed_rows.push_back(item_row(adc_seq_pkg::FUNC_SAMPLE, 4'd0, 16'd0, 32'h0000_FF7F,
                                     1'b0, 16'd0, 4'd0));
    directed_rows.push_back(item_row(adc_seq_pkg::FUNC_SAMPLE, 4'd0, 16'd0, 32'h0000_0080,
                                     1'b0, 16'd0, 4'd0));
    // Temperature and a second voltage channel join the scan.
    directed_rows.push_back(item_row(adc_seq_pkg::FUNC_WRITE, CH_TEMP, 16'h8001, 32'd0,
                                     1'b1, 16'd0, CH_NONE));
    directed_rows.push_back(item_row(adc_seq_pkg::FUNC_WRITE, 4'd3, 16'h0001, 32'd0,
                                     1'b1, 16'd0, CH_NONE));
    directed_rows.push_back(item_row(adc_seq_pkg::FUNC_SAMPLE, 4'd0, 16'd0, 32'h5A5A_1234,
                                     1'b0, 16'd0, 4'd0));
    directed_rows.push_back(item_row(adc_seq_pkg::FUNC_SAMPLE, 4'd0, 16'd0, 32'hFFFF_0000,
                                     1'b0, 16'd0, 4'd0));
    directed_rows.push_back(item_row(adc_seq_pkg::FUNC_SAMPLE, 4'd0, 16'd0, 32'h0000_FFFF,
                                     1'b0, 16'd0, 4'd0));
    directed_rows.push_back(item_row(adc_seq_pkg::FUNC_SAMPLE, 4'd0, 16'd0, 32'h8001_00FF,
                                     1'b0, 16'd0, 4'd0));
    // Read-back check on a narrow mask: a fault, the suppressed report, a match.
    directed_rows.push_back(cfg_row(adc_seq_pkg::REG_CONFIG_CHECK, 32'd1));
    directed_rows.push_back(cfg_row(adc_seq_pkg::REG_COMPARE_MASK, 32'h0000_00FF));
    directed_rows.push_back(item_row(adc_seq_pkg::FUNC_SAMPLE, 4'd0, 16'd0, 32'h0000_3C3C,
                                     1'b0, 16'd0, 4'd0));
    directed_rows.push_back(item_row(adc_seq_pkg::FUNC_SAMPLE, 4'd0, 16'd0, 32'h1234_5678,
                                     1'b0, 16'd0, 4'd0));
    directed_rows.push_back(item_row(adc_seq_pkg::FUNC_SAMPLE, 4'd0, 16'd0, 32'hAB01_0102,
                                     1'b0, 16'd0, 4'd0));
    // A zero divider acts as one; then every channel is disabled again.
    directed_rows.push_back(cfg_row(adc_seq_pkg::REG_TEMP_DIVIDER, 32'd0));
    directed_rows.push_back(item_row(adc_seq_pkg::FUNC_SAMPLE, 4'd0, 16'd0, 32'h7FFF_8000,
                                     1'b0, 16'd0, 4'd0));
    directed_rows.push_back(item_row(adc_seq_pkg::FUNC_WRITE, 4'd3, 16'd0, 32'd0,
                                     1'b1, 16'd0, CH_NONE));
    directed_rows.push_back(item_row(adc_seq_pkg::FUNC_WRITE, 4'd0, 16'd0, 32'd0,
                                     1'b1, 16'd0, CH_NONE));
    directed_rows.push_back(item_row(adc_seq_pkg::FUNC_WRITE, CH_TEMP, 16'd0, 32'd0,
                                     1'b1, 16'd0, CH_NONE));
    directed_rows.push_back(item_row(adc_seq_pkg::FUNC_SAMPLE, 4'd0, 16'd0, 32'h0102_0304,
                                     1'b0, 16'd0, 4'd0));

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        wait_drained();
        cfg_write(directed_rows[i].reg_idx, directed_rows[i].reg_val);
      end else begin
        send_item(directed_rows[i].item, directed_rows[i].known, directed_rows[i].typed);
        idle_sender(gap_len());
      end
    end

    // Random phases, each under its own register setting.
    for (int p = 0; p < RAND_PHASES; p++) begin
      wait_drained();
      quiet = (p % 3 == 2);
      if (p == 0) begin
        cfg_write(adc_seq_pkg::REG_TEMP_DIVIDER, 32'd65535);
        cfg_write(adc_seq_pkg::REG_CONFIG_CHECK, 32'd1);
        cfg_write(adc_seq_pkg::REG_COMPARE_MASK, 32'd0);
      end else if (p == 1) begin
        cfg_write(adc_seq_pkg::REG_TEMP_DIVIDER, 32'd2);
        cfg_write(adc_seq_pkg::REG_CONFIG_CHECK, 32'd1);
        cfg_write(adc_seq_pkg::REG_COMPARE_MASK, 32'hFFFF);
      end else begin
        r = $urandom_range(0, 5);
        cfg_write(adc_seq_pkg::REG_TEMP_DIVIDER, (r == 0) ? 32'd0 : (r == 1) ? 32'd1 :
                  (r == 2) ? 32'd65535 : 32'($urandom_range(1, 12)));
        cfg_write(adc_seq_pkg::REG_CONFIG_CHECK, 32'($urandom_range(0, 1)));
        r = $urandom_range(0, 3);
        cfg_write(adc_seq_pkg::REG_COMPARE_MASK, (r == 0) ? 32'hFFFF : (r == 1) ? 32'd0 :
                  32'($urandom_range(0, 65535)));
      end
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if ($urandom_range(0, 99) < 70) begin
          it = make_item(adc_seq_pkg::FUNC_SAMPLE, 4'($urandom_range(0, 15)),
                         16'($urandom()), $urandom());
          // With the check on, the read-back mostly agrees on the masked bits.
          if (check_reg && $urandom_range(0, 9) < 6) begin
            peek = predict_scan(it, 1'b0);
            rb = peek.tx_word ^ (16'($urandom()) & ~mask_reg);
            it.rx_data[31:16] = rb;
          end
        end else begin
          it = make_item(adc_seq_pkg::FUNC_WRITE,
                         ($urandom_range(0, 9) != 0) ? 4'($urandom_range(0, NUM_CH - 1))
                                                     : 4'($urandom_range(NUM_CH, 15)),
                         ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom()),
                         $urandom());
        end
        send_item(it, 1'b0, '0);
        if ($urandom_range(0, 59) == 0) wait_drained();
        else idle_sender(gap_len());
      end
    end

    wait_drained();
    repeat (30) @(posedge clk);
    if (mismatches == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
